/* rtl/multichannel_tick_divider_queue_core_macros.svh */
// Assertion helpers shared by the tick divider queue RTL.
// All checks sample on the rising clock edge and are held off during reset.
`ifndef MULTICHANNEL_TICK_DIVIDER_QUEUE_CORE_MACROS_SVH
`define MULTICHANNEL_TICK_DIVIDER_QUEUE_CORE_MACROS_SVH

// Check a property on every clock edge outside reset
`define MTDQ_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle
`define MTDQ_CHECK_NEXT(label, ante, cons, msg) \
   `MTDQ_CHECK(label, (ante) |=> (cons), msg)

`endif

/* rtl/mtdq_pkg.sv */
`default_nettype none

package mtdq_pkg;

   // fixed field widths
   localparam int CMD_W     = 2;
   localparam int CHAN_IN_W = 8;
   localparam int FACTOR_W  = 8;
   localparam int STATUS_W  = 2;
   localparam int RUN_CH_W  = 3;
   localparam int PENDING_W = 5;

   // command codes
   localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DRAIN   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ENABLE  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_DISABLE = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]     command;
      logic [CHAN_IN_W-1:0] channel;
      logic [FACTOR_W-1:0]  divide_factor;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic                 run_valid;
      logic [RUN_CH_W-1:0]  run_channel;
      logic                 dropped;
      logic [PENDING_W-1:0] pending;
   } rsp_type;

   // control from the sequencer to the channel table
   typedef struct packed {
      logic wr_en;   // enable or disable write at the selected channel
      logic wr_arm;  // 1 arms with the new factor, 0 disarms and clears
      logic step;    // advance the counter of the selected channel
   } chan_ctl_type;

endpackage

`default_nettype wire

/* rtl/mtdq_ram.sv */
`default_nettype none

module mtdq_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/mtdq_chan.sv */
`default_nettype none

module mtdq_chan #(
   parameter int CHANNELS = 8
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  mtdq_pkg::chan_ctl_type                       ctl,
   input  logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] index,
   input  logic [mtdq_pkg::FACTOR_W-1:0]                factor,
   output logic [CHANNELS-1:0]                          armed,
   output logic                                         fire
);

   logic [CHANNELS-1:0]             armed_ff, armed_in;
   logic [mtdq_pkg::FACTOR_W-1:0]   factor_ff [CHANNELS];
   logic [mtdq_pkg::FACTOR_W-1:0]   factor_in [CHANNELS];
   logic [mtdq_pkg::FACTOR_W-1:0]   count_ff  [CHANNELS];
   logic [mtdq_pkg::FACTOR_W-1:0]   count_in  [CHANNELS];
   logic [mtdq_pkg::FACTOR_W-1:0]   count_inc;

   // shared unit: bump the selected counter and compare against its factor
   assign count_inc = count_ff[index] + mtdq_pkg::FACTOR_W'(1);
   assign fire      = armed_ff[index] && (count_inc >= factor_ff[index]);
   assign armed     = armed_ff;

   // update the selected channel only
   always_comb begin
      armed_in  = armed_ff;
      factor_in = factor_ff;
      count_in  = count_ff;
      if (ctl.wr_en) begin
         armed_in[index]  = ctl.wr_arm;
         factor_in[index] = ctl.wr_arm ? factor : '0;
         count_in[index]  = '0;
      end else if (ctl.step && armed_ff[index]) begin
         count_in[index] = fire ? '0 : count_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            factor_ff[i] <= '0;
            count_ff[i]  <= '0;
         end
      end else begin
         armed_ff  <= armed_in;
         factor_ff <= factor_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/multichannel_tick_divider_queue_core.sv */
`default_nettype none
// Multichannel tick divider with a firing queue.
// Input: a command word on req_data is taken at a clock edge where start is
// high and busy is low. Commands: tick, drain one queued channel, enable a
// channel with a divide factor, disable a channel.
// Output: exactly one response word per command, shown on rsp_data for one
// cycle with rsp_valid high. The receiver cannot hold it off; it must take
// the word in that cycle.
// Sequence per command from the accepting edge to the response cycle:
//   tick            walks the channels one per cycle through the shared
//                   increment and compare unit, then responds
//   drain           reads the queue memory (the read is registered), then
//                   responds; an empty queue responds without a read
//   enable/disable  updates the channel table if in range and responds
// busy goes high after the accepting edge and stays high through the response
// cycle; the next command may be accepted in the cycle after the strobe.
// Reset clears all channel state and the queue pointers at once; the queue
// memory itself is not cleared, only written entries are ever read.
module multichannel_tick_divider_queue_core #(
   parameter int CHANNELS    = 8,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mtdq_pkg::req_type req_data,
   output logic              rsp_valid,
   output mtdq_pkg::rsp_type rsp_data
);

`include "multichannel_tick_divider_queue_core_macros.svh"

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int QW   = $clog2(QUEUE_DEPTH);
   localparam int FW   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_WALK = 4'b0010,
      S_POP  = 4'b0100,
      S_RESP = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [CH_W-1:0] idx_ff, idx_in;
   logic [QW-1:0]   head_ff, head_in;
   logic [QW-1:0]   tail_ff, tail_in;
   logic [FW-1:0]   fill_ff, fill_in;
   logic [mtdq_pkg::STATUS_W-1:0] status_ff, status_in;
   logic            run_valid_ff, run_valid_in;
   logic [mtdq_pkg::RUN_CH_W-1:0] run_ch_ff, run_ch_in;
   logic            dropped_ff, dropped_in;

   mtdq_pkg::chan_ctl_type chan_ctl;
   logic [CH_W-1:0]     chan_index;
   logic [CHANNELS-1:0] armed;
   logic                fire;

   logic            q_wr_en;
   logic            q_rd_en;
   logic [CH_W-1:0] q_rd_data;
   logic [mtdq_pkg::CHAN_IN_W-1:0] pop_ext;
   logic            pop_live;

   mtdq_chan #(
      .CHANNELS (CHANNELS)
   ) u_chan (
      .clock  (clock),
      .reset  (reset),
      .ctl    (chan_ctl),
      .index  (chan_index),
      .factor (req_data.divide_factor),
      .armed  (armed),
      .fire   (fire)
   );

   mtdq_ram #(
      .WIDTH (CH_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (tail_ff),
      .wr_data (idx_ff),
      .rd_en   (q_rd_en),
      .rd_addr (head_ff),
      .rd_data (q_rd_data)
   );

   // popped channel counts only if in range and still armed
   assign pop_ext  = mtdq_pkg::CHAN_IN_W'(q_rd_data);
   assign pop_live = (pop_ext < mtdq_pkg::CHAN_IN_W'(CHANNELS)) && armed[q_rd_data];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      status_in    = status_ff;
      run_valid_in = run_valid_ff;
      run_ch_in    = run_ch_ff;
      dropped_in   = dropped_ff;
      chan_ctl     = '0;
      chan_index   = idx_ff;
      q_wr_en      = 1'b0;
      q_rd_en      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               status_in    = mtdq_pkg::ST_OK;
               run_valid_in = 1'b0;
               run_ch_in    = '0;
               dropped_in   = 1'b0;
               idx_in       = '0;
               case (req_data.command)
                  mtdq_pkg::CMD_TICK: begin
                     state_in = S_WALK;
                  end
                  mtdq_pkg::CMD_DRAIN: begin
                     if (fill_ff == '0) begin
                        status_in = mtdq_pkg::ST_EMPTY;
                        state_in  = S_RESP;
                     end else begin
                        q_rd_en  = 1'b1;
                        head_in  = (head_ff == QW'(QUEUE_DEPTH - 1)) ?
                                   '0 : head_ff + QW'(1);
                        fill_in  = fill_ff - FW'(1);
                        state_in = S_POP;
                     end
                  end
                  default: begin
                     // enable or disable one channel
                     if (req_data.channel >= mtdq_pkg::CHAN_IN_W'(CHANNELS)) begin
                        status_in = mtdq_pkg::ST_RANGE;
                     end else begin
                        chan_index      = req_data.channel[CH_W-1:0];
                        chan_ctl.wr_en  = 1'b1;
                        chan_ctl.wr_arm = (req_data.command == mtdq_pkg::CMD_ENABLE);
                     end
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_WALK: begin
            // one channel per cycle; push firings, drop them when full
            chan_ctl.step = 1'b1;
            if (fire) begin
               if (fill_ff == FW'(QUEUE_DEPTH)) begin
                  dropped_in = 1'b1;
               end else begin
                  q_wr_en = 1'b1;
                  tail_in = (tail_ff == QW'(QUEUE_DEPTH - 1)) ?
                            '0 : tail_ff + QW'(1);
                  fill_in = fill_ff + FW'(1);
               end
            end
            if (idx_ff == CH_W'(CHANNELS - 1)) begin
               state_in = S_RESP;
            end else begin
               idx_in = idx_ff + CH_W'(1);
            end
         end
         S_POP: begin
            run_valid_in = pop_live;
            run_ch_in    = pop_live ? pop_ext[mtdq_pkg::RUN_CH_W-1:0] : '0;
            state_in     = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         fill_ff  <= fill_in;
      end
   end

   // response payload and walk index hold without reset
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      status_ff    <= status_in;
      run_valid_ff <= run_valid_in;
      run_ch_ff    <= run_ch_in;
      dropped_ff   <= dropped_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      rsp_data             = '0;
      rsp_data.status      = status_ff;
      rsp_data.run_valid   = run_valid_ff;
      rsp_data.run_channel = run_ch_ff;
      rsp_data.dropped     = dropped_ff;
      rsp_data.pending     = mtdq_pkg::PENDING_W'(fill_ff);
   end

   // checks
   `MTDQ_CHECK(a_fill_bound, fill_ff <= FW'(QUEUE_DEPTH), "queue fill above depth")
   `MTDQ_CHECK_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
   `MTDQ_CHECK_NEXT(a_rsp_release, rsp_valid, !busy && !rsp_valid, "busy held after response")
   `MTDQ_CHECK(a_drop_full,
      (rsp_valid && rsp_data.dropped) |-> (fill_ff == FW'(QUEUE_DEPTH)),
      "drop reported with queue not full")
   `MTDQ_CHECK(a_run_ok,
      (rsp_valid && rsp_data.run_valid) |-> (rsp_data.status == mtdq_pkg::ST_OK),
      "run reported with bad status")

endmodule

`default_nettype wire
